/* hdl/p25f_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// p25f_pkg
// Shared types, record templates and byte selection for the network framer.
// ============================================================================
package p25f_pkg;

    localparam int NUM_RECORDS = 18;
    localparam int MAX_LEN     = 22;
    localparam int VOICE_LEN   = 11;

    localparam logic [4:0] TERM_LEN  = 5'd17;
    localparam logic [7:0] TERM_HEAD = 8'h80;
    localparam logic [7:0] FORCE_70  = 8'h80;

    // item action codes
    localparam logic ACT_VOICE = 1'b0;
    localparam logic ACT_END   = 1'b1;

    // steps that carry special fields
    localparam logic [4:0] STEP_LAST = 5'd17;
    localparam logic [4:0] STEP_DST  = 5'd3;   // record 0x65
    localparam logic [4:0] STEP_SRC  = 5'd4;   // record 0x66
    localparam logic [4:0] STEP_70   = 5'd14;  // record 0x70

    // configuration register indexes
    localparam logic CFG_DST = 1'b0;
    localparam logic CFG_SRC = 1'b1;

    typedef struct packed {
        logic        action;
        logic [4:0]  step;
        logic [23:0] head;
        logic [63:0] tail;
    } t_item;

    // record templates, byte 0 in the top bits
    localparam logic [175:0] REC_ROM [NUM_RECORDS] = '{
        176'h6202020C0B1264000080_000000000000000000000000,
        176'h63_000000000000000000000000_02_0000000000000000,
        176'h64_000000000000000000000000000000_02_0000000000,
        176'h65_000000000000000000000000000000_02_0000000000,
        176'h66_000000000000000000000000000000_02_0000000000,
        176'h67F09D6A_000000000000000000000000_02_0000000000,
        176'h6819D426_000000000000000000000000_02_0000000000,
        176'h69E0EB7B_000000000000000000000000_02_0000000000,
        176'h6A000002_000000000000000000000000000000000000,
        176'h6B02020C0B1264000080_000000000000000000000000,
        176'h6C_000000000000000000000000_02_0000000000000000,
        176'h6D_000000000000000000000000000000_02_0000000000,
        176'h6E_000000000000000000000000000000_02_0000000000,
        176'h6F_000000000000000000000000000000_02_0000000000,
        176'h70_000000000000000000000000000000_02_0000000000,
        176'h71ACB8A4_000000000000000000000000_02_0000000000,
        176'h729BDC75_000000000000000000000000_02_0000000000,
        176'h73000002_000000000000000000000000000000000000
    };

    function automatic logic [4:0] fix_step(input logic [4:0] step);
        return (step > STEP_LAST) ? 5'd0 : step;
    endfunction

    function automatic logic [4:0] rec_len(input t_item it);
        logic [4:0] s;
        s = fix_step(it.step);
        if (it.action == ACT_END) return TERM_LEN;
        case (s)
            5'd0, 5'd9:   return 5'd22;
            5'd1, 5'd10:  return 5'd14;
            5'd8, 5'd17:  return 5'd16;
            default:      return 5'd17;
        endcase
    endfunction

    function automatic logic [4:0] voice_at(input logic [4:0] s);
        case (s)
            5'd0, 5'd9:   return 5'd10;
            5'd1, 5'd10:  return 5'd1;
            5'd8, 5'd17:  return 5'd4;
            default:      return 5'd5;
        endcase
    endfunction

    function automatic logic [7:0] rec_byte(input t_item it, input logic [4:0] idx,
                                            input logic [23:0] dst, input logic [23:0] src);
        logic [4:0]   s;
        logic [175:0] row;
        logic [87:0]  vv;
        logic [4:0]   at;
        logic [4:0]   off;
        logic [7:0]   b;
        s   = fix_step(it.step);
        row = REC_ROM[s];
        vv  = {it.head, it.tail};
        at  = voice_at(s);
        off = idx - at;
        b   = row[175 - 8 * int'(idx) -: 8];
        if (idx >= at && off < 5'(VOICE_LEN)) begin
            for (int j = 0; j < VOICE_LEN; j++) begin
                if (off == 5'(j)) begin
                    b = vv[87 - 8 * j -: 8];
                end
            end
        end
        if (s == STEP_DST || s == STEP_SRC) begin
            case (idx)
                5'd1:    b = (s == STEP_DST) ? dst[23:16] : src[23:16];
                5'd2:    b = (s == STEP_DST) ? dst[15:8]  : src[15:8];
                5'd3:    b = (s == STEP_DST) ? dst[7:0]   : src[7:0];
                default: b = b;
            endcase
        end else if (s == STEP_70 && idx == 5'd1) begin
            b = FORCE_70;
        end
        if (it.action == ACT_END) begin
            b = (idx == 5'd0) ? TERM_HEAD : 8'h00;
        end
        return b;
    endfunction

endpackage

/* hdl/p25_network_voice_framer.sv */
`timescale 1ns / 1ps
// ============================================================================
// p25_network_voice_framer
// Wraps vocoder frames in the rotating set of eighteen network voice records
// and emits each record byte by byte with a last-byte mark.
// ============================================================================
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  ---------------------------
//  in        to block   i_in_valid / o_in_stall      i_action, i_voice_head,
//                                                    i_voice_tail
//  out       from block o_out_valid / i_out_stall    o_out_byte, o_last_byte
//  cfg       to block   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  Each item produces 14 to 22 output bytes, one byte per cycle unless the
//  output stalls, so the sustained rate is set by the output record length.
//  Items queue in a DEPTH-entry RAM; input stalls only when it is full.
//  First byte follows the RAM read, prefetch, current-item and output registers.
//  Synchronous active-low reset clears step, queue pointers and valid flags.
//  An output stall holds the current byte; the queue keeps taking items.
//
module p25_network_voice_framer #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [23:0] i_voice_head,
    input  logic [63:0] i_voice_tail,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import p25f_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [23:0]   r_dst;
    logic [23:0]   r_src;
    logic [4:0]    r_step;
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    logic          in_acc;
    logic          rd_req;
    t_item         wr_item;
    t_item         rd_item;
    logic [4:0]    n_step;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_count == CW'(DEPTH));
    assign in_acc      = i_in_valid && !o_in_stall;

    // stamp the item with its record step at acceptance
    assign wr_item.action = i_action;
    assign wr_item.step   = fix_step(r_step);
    assign wr_item.head   = i_voice_head;
    assign wr_item.tail   = i_voice_tail;

    always_comb begin
        if (i_action == ACT_END) begin
            n_step = 5'd0;
        end else if (fix_step(r_step) == STEP_LAST) begin
            n_step = 5'd0;
        end else begin
            n_step = fix_step(r_step) + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst   <= 24'd0;
            r_src   <= 24'd0;
            r_step  <= 5'd0;
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_DST) begin
                    r_dst <= i_cfg_data;
                end else begin
                    r_src <= i_cfg_data;
                end
            end
            if (in_acc) begin
                r_step <= n_step;
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (rd_req) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            // hold count when one enters and one leaves together
            r_count <= r_count + CW'(in_acc) - CW'(rd_req);
        end
    end

    p25f_ram #(
        .WIDTH ($bits(t_item)),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wptr),
        .i_wdata (wr_item),
        .i_re    (rd_req),
        .i_raddr (r_rptr),
        .o_rdata (rd_item)
    );

    p25f_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (r_count != '0),
        .o_rd_req     (rd_req),
        .i_rd_item    (rd_item),
        .i_dst        (r_dst),
        .i_src        (r_src),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule

/* hdl/p25f_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// p25f_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module p25f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/p25f_serializer.sv */
`timescale 1ns / 1ps
// ============================================================================
// p25f_serializer
// Prefetches queued items; emits records one byte per cycle unless stalled.
// ============================================================================
module p25f_serializer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_nonempty,
    output logic                 o_rd_req,
    input  p25f_pkg::t_item      i_rd_item,
    input  logic [23:0]          i_dst,
    input  logic [23:0]          i_src,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_byte
);
    import p25f_pkg::*;

    t_item      r_cur;
    t_item      r_nx;
    logic       r_busy;
    logic       r_nx_valid;
    logic       r_rd_pend;
    logic [4:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_last;

    logic       adv;
    logic       is_last;
    logic       load;

    assign adv      = r_busy && (!r_out_valid || !i_out_stall);
    assign is_last  = (r_idx == rec_len(r_cur) - 5'd1);
    assign load     = r_nx_valid && (!r_busy || (adv && is_last));
    assign o_rd_req = i_q_nonempty && !r_rd_pend && !r_nx_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_nx_valid  <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_idx       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= o_rd_req;
            if (r_rd_pend) begin
                r_nx       <= i_rd_item;
                r_nx_valid <= 1'b1;
            end else if (load) begin
                r_nx_valid <= 1'b0;
            end
            if (adv) begin
                r_out_byte  <= rec_byte(r_cur, r_idx, i_dst, i_src);
                r_last      <= is_last;
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 5'd0 : r_idx + 5'd1;
                if (is_last) begin
                    r_busy <= load;
                end
            end else begin
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
                if (load) begin
                    r_busy <= 1'b1;
                end
            end
            if (load) begin
                r_cur <= r_nx;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_last;

endmodule
